### hdl/sdod_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the segment/disk overlap density block.
// No dependencies.
package sdod_pkg;

  localparam int unsigned DensW = 48;
  localparam int unsigned RadW  = 31;

  localparam logic [DensW-1:0] DensMax     = {DensW{1'b1}};
  localparam logic [RadW-1:0]  RadiusReset = RadW'(65536);

  // magnitude of a 33-bit two's complement value
  function automatic logic [32:0] mag33(logic signed [32:0] v);
    logic [32:0] r;
    r = v[32] ? 33'(-v) : 33'(v);
    return r;
  endfunction

  // magnitude of a 50-bit two's complement value
  function automatic logic [49:0] mag50(logic signed [49:0] v);
    logic [49:0] r;
    r = v[49] ? 50'(-v) : 50'(v);
    return r;
  endfunction

endpackage

### hdl/segment_disk_overlap_density.sv
`timescale 1ns / 1ps
// Segment/disk overlap density: covered segment length summed per pixel.
// Depends on sdod_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, pixel/seg fields  | into block
//  out     | out_valid_o, out_stall_i, density, sat    | out of block
//  cfg     | cfg_we_i, cfg_wdata_i (radius)            | into block
//
// One word at a time. Each product runs four 32x32 partial products through
// one multiplier, square roots are taken bit-serially and each root division
// yields one bit per cycle. rst_ni clears the density, the saturation flag and
// sets radius to 1.0. A stalled result only holds the block in its final
// accumulate step.
module segment_disk_overlap_density (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sdod_pkg::RadW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [31:0]          pixel_x_i,
  input  logic signed [31:0]          pixel_y_i,
  input  logic signed [31:0]          seg_x_start_i,
  input  logic signed [31:0]          seg_y_start_i,
  input  logic signed [31:0]          seg_x_end_i,
  input  logic signed [31:0]          seg_y_end_i,
  input  logic signed [31:0]          seg_slope_i,
  input  logic signed [31:0]          seg_intercept_i,
  input  logic                        first_of_pixel_i,
  input  logic                        last_of_pixel_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sdod_pkg::DensW-1:0]  density_o,
  output logic                        saturated_o
);
  import sdod_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL, ST_SQRT, ST_DIV,
    ST_L0, ST_L1, ST_L2, ST_L3, ST_L4, ST_L5,
    ST_B1, ST_B2, ST_B3,
    ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_Q5, ST_Q6, ST_Q7, ST_Q8, ST_Q9,
    ST_ACC
  } state_e;

  state_e state_q, ret_q;

  logic [RadW-1:0]  radius_q;
  logic [DensW-1:0] dens_q;
  logic             sat_q;
  logic             out_valid_q;

  logic signed [31:0] px_q, py_q, xs_q, ys_q, xe_q, ye_q, m_q, k_q;
  logic               last_q;
  logic               in_l_q, in_r_q;

  // shared multiplier
  logic [63:0]  mul_a_q, mul_b_q;
  logic [127:0] prod_q;
  logic [1:0]   mcnt_q;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [1:0]   sh_sel;

  // square root
  logic [127:0] sq_op_q, sq_res_q, sq_one_q, sq_trial;
  logic [5:0]   sq_cnt_q;
  logic         sq_ge;

  // divider
  logic [95:0]  dv_num_q;
  logic [63:0]  dv_rem_q;
  logic [46:0]  dv_quo_q;
  logic         dv_neg_q;
  logic [6:0]   dv_cnt_q;
  logic [64:0]  dv_rem2;
  logic         dv_ge;

  // item temporaries
  logic [65:0]         dist_q;
  logic [62:0]         a_q;
  logic signed [63:0]  d_q;
  logic [127:0]        ar2_q;
  logic [63:0]         s_q;
  logic [31:0]         qa_q;
  logic signed [96:0]  num_hi_q;
  logic signed [48:0]  ell_q;
  logic [63:0]         len_q;

  // combinational helpers
  logic [32:0]         mag_xs, mag_ys, mag_xe, mag_ye, mag_ex, mag_ey;
  logic signed [64:0]  d_w;
  logic [63:0]         d_mag;
  logic signed [96:0]  base_w, sh_w, num_lo_w;
  logic signed [47:0]  q_signed;
  logic signed [48:0]  pos_w;
  logic signed [49:0]  dx_us, dx_ee, dx_ue;
  logic [63:0]         sum_w;
  logic [96:0]         num_lo_mag;
  logic [96:0]         num_hi_mag;
  logic                acc_emit;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    mag_xs = mag33(33'(px_q) - 33'(xs_q));
    mag_ys = mag33(33'(py_q) - 33'(ys_q));
    mag_xe = mag33(33'(px_q) - 33'(xe_q));
    mag_ye = mag33(33'(py_q) - 33'(ye_q));
    mag_ex = mag33(33'(xe_q) - 33'(xs_q));
    mag_ey = mag33(33'(ye_q) - 33'(ys_q));

    pa = mcnt_q[1] ? mul_a_q[63:32] : mul_a_q[31:0];
    pb = mcnt_q[0] ? mul_b_q[63:32] : mul_b_q[31:0];
    pp = {32'b0, pa} * {32'b0, pb};
    sh_sel = {1'b0, mcnt_q[1]} + {1'b0, mcnt_q[0]};
    unique case (sh_sel)
      2'd1:    pp_sh = {32'b0, pp, 32'b0};
      2'd2:    pp_sh = {pp, 64'b0};
      default: pp_sh = {64'b0, pp};
    endcase

    sq_trial = sq_res_q + sq_one_q;
    sq_ge    = (sq_op_q >= sq_trial);

    dv_rem2 = {dv_rem_q, dv_num_q[95]};
    dv_ge   = (dv_rem2 >= {2'b0, a_q});

    // line offset d = k*2^16 + m*px - py*2^16, product magnitude in prod_q
    d_w = {{17{k_q[31]}}, k_q, 16'b0}
        + ((m_q[31] ^ px_q[31]) ? -{2'b0, prod_q[62:0]} : {2'b0, prod_q[62:0]})
        - {{17{py_q[31]}}, py_q, 16'b0};
    d_mag = d_q[63] ? 64'(-d_q) : 64'(d_q);

    // base = -(m*d), magnitude in prod_q
    base_w   = (m_q[31] != d_q[63]) ? {2'b0, prod_q[94:0]} : -{2'b0, prod_q[94:0]};
    sh_w     = {17'b0, s_q, 16'b0};
    num_lo_w = base_w - sh_w;
    num_lo_mag = num_lo_w[96] ? 97'(-num_lo_w) : 97'(num_lo_w);
    num_hi_mag = num_hi_q[96] ? 97'(-num_hi_q) : 97'(num_hi_q);

    q_signed = dv_neg_q ? -{1'b0, dv_quo_q} : {1'b0, dv_quo_q};
    pos_w    = 49'(px_q) + 49'(q_signed);

    dx_us = 50'(pos_w) - 50'(xs_q);
    dx_ee = 50'(xe_q) - 50'(ell_q);
    dx_ue = 50'(pos_w) - 50'(ell_q);

    sum_w = {16'b0, dens_q} + len_q;

    // final accumulate of a last-marked word loads the result register
    acc_emit = (state_q == ST_ACC) && (ret_q != ST_ACC) && last_q
            && !(out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      radius_q    <= RadiusReset;
      dens_q      <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      density_o   <= '0;
      saturated_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      if (acc_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            px_q   <= pixel_x_i;
            py_q   <= pixel_y_i;
            xs_q   <= seg_x_start_i;
            ys_q   <= seg_y_start_i;
            xe_q   <= seg_x_end_i;
            ye_q   <= seg_y_end_i;
            m_q    <= seg_slope_i;
            k_q    <= seg_intercept_i;
            last_q <= last_of_pixel_i;
            if (first_of_pixel_i) begin
              dens_q <= '0;
              sat_q  <= 1'b0;
            end
            state_q <= ST_L0;
          end
        end
        ST_MUL: begin
          prod_q <= prod_q + pp_sh;
          mcnt_q <= mcnt_q + 2'd1;
          if (mcnt_q == 2'd3) begin
            state_q <= ret_q;
          end
        end
        ST_SQRT: begin
          if (sq_ge) begin
            sq_op_q  <= sq_op_q - sq_trial;
            sq_res_q <= (sq_res_q >> 1) + sq_one_q;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_one_q <= sq_one_q >> 2;
          sq_cnt_q <= sq_cnt_q - 6'd1;
          if (sq_cnt_q == 6'd0) begin
            state_q <= ret_q;
          end
        end
        ST_DIV: begin
          dv_rem_q <= dv_ge ? 64'(dv_rem2 - {2'b0, a_q}) : dv_rem2[63:0];
          dv_quo_q <= {dv_quo_q[45:0], dv_ge};
          dv_num_q <= {dv_num_q[94:0], 1'b0};
          dv_cnt_q <= dv_cnt_q - 7'd1;
          if (dv_cnt_q == 7'd0) begin
            state_q <= ret_q;
          end
        end
        ST_L0: begin
          mul_a_q <= 64'(mag_xs); mul_b_q <= 64'(mag_xs);
          prod_q <= '0; mcnt_q <= '0; ret_q <= ST_L1; state_q <= ST_MUL;
        end
        ST_L1: begin
          dist_q  <= prod_q[65:0];
          mul_a_q <= 64'(mag_ys); mul_b_q <= 64'(mag_ys);
          prod_q <= '0; mcnt_q <= '0; ret_q <= ST_L2; state_q <= ST_MUL;
        end
        ST_L2: begin
          dist_q  <= dist_q + prod_q[65:0];
          mul_a_q <= 64'(mag_xe); mul_b_q <= 64'(mag_xe);
          prod_q <= '0; mcnt_q <= '0; ret_q <= ST_L3; state_q <= ST_MUL;
        end
        ST_L3: begin
          in_l_q  <= 1'b0;
          ar2_q   <= {62'b0, prod_q[65:0]};
          mul_a_q <= 64'(mag_ye); mul_b_q <= 64'(mag_ye);
          prod_q <= '0; mcnt_q <= '0; ret_q <= ST_L4; state_q <= ST_MUL;
        end
        ST_L4: begin
          // ar2_q briefly holds the end point distance
          ar2_q   <= {62'b0, ar2_q[65:0] + prod_q[65:0]};
          mul_a_q <= 64'(radius_q); mul_b_q <= 64'(radius_q);
          prod_q <= '0; mcnt_q <= '0; ret_q <= ST_L5; state_q <= ST_MUL;
        end
        ST_L5: begin
          in_l_q <= (dist_q <= prod_q[65:0]);
          in_r_q <= (ar2_q[65:0] <= prod_q[65:0]);
          if ((dist_q <= prod_q[65:0]) && (ar2_q[65:0] <= prod_q[65:0])) begin
            mul_a_q <= 64'(mag_ex); mul_b_q <= 64'(mag_ex);
            prod_q <= '0; mcnt_q <= '0; ret_q <= ST_B1; state_q <= ST_MUL;
          end else begin
            mul_b_q <= prod_q[63:0];  // r^2 kept for the a*r^2 product
            state_q <= ST_Q0;
          end
        end
        ST_B1: begin
          dist_q  <= prod_q[65:0];
          mul_a_q <= 64'(mag_ey); mul_b_q <= 64'(mag_ey);
          prod_q <= '0; mcnt_q <= '0; ret_q <= ST_B2; state_q <= ST_MUL;
        end
        ST_B2: begin
          sq_op_q  <= {62'b0, dist_q + prod_q[65:0]};
          sq_res_q <= '0;
          sq_one_q <= {2'b01, 126'b0};
          sq_cnt_q <= 6'd63;
          ret_q    <= ST_B3;
          state_q  <= ST_SQRT;
        end
        ST_B3: begin
          len_q   <= sq_res_q[63:0];
          state_q <= ST_ACC;
        end
        ST_Q0: begin
          // r^2 moves into dist_q while m*m runs
          dist_q  <= {2'b0, mul_b_q};
          mul_a_q <= 64'(mag33(33'(m_q))); mul_b_q <= 64'(mag33(33'(m_q)));
          prod_q <= '0; mcnt_q <= '0; ret_q <= ST_Q1; state_q <= ST_MUL;
        end
        ST_Q1: begin
          a_q     <= 63'(64'h1_0000_0000 + {1'b0, prod_q[62:0]});
          mul_a_q <= 64'(mag33(33'(m_q))); mul_b_q <= 64'(mag33(33'(px_q)));
          prod_q <= '0; mcnt_q <= '0; ret_q <= ST_Q2; state_q <= ST_MUL;
        end
        ST_Q2: begin
          d_q     <= d_w[63:0];
          mul_a_q <= {1'b0, a_q}; mul_b_q <= dist_q[63:0];
          prod_q <= '0; mcnt_q <= '0; ret_q <= ST_Q3; state_q <= ST_MUL;
        end
        ST_Q3: begin
          ar2_q   <= prod_q;
          mul_a_q <= d_mag; mul_b_q <= d_mag;
          prod_q <= '0; mcnt_q <= '0; ret_q <= ST_Q4; state_q <= ST_MUL;
        end
        ST_Q4: begin
          if (ar2_q < prod_q) begin
            len_q   <= '0;
            state_q <= ST_ACC;
          end else begin
            sq_op_q  <= ar2_q - prod_q;
            sq_res_q <= '0;
            sq_one_q <= {2'b01, 126'b0};
            sq_cnt_q <= 6'd63;
            ret_q    <= ST_Q5;
            state_q  <= ST_SQRT;
          end
        end
        ST_Q5: begin
          s_q      <= sq_res_q[63:0];
          sq_op_q  <= {65'b0, a_q};
          sq_res_q <= '0;
          sq_one_q <= {2'b01, 126'b0};
          sq_cnt_q <= 6'd63;
          ret_q    <= ST_Q6;
          state_q  <= ST_SQRT;
        end
        ST_Q6: begin
          qa_q    <= sq_res_q[31:0];
          mul_a_q <= 64'(mag33(33'(m_q))); mul_b_q <= d_mag;
          prod_q <= '0; mcnt_q <= '0; ret_q <= ST_Q7; state_q <= ST_MUL;
        end
        ST_Q7: begin
          num_hi_q <= base_w + sh_w;
          dv_neg_q <= num_lo_w[96];
          dv_num_q <= num_lo_mag[95:0];
          dv_rem_q <= '0;
          dv_quo_q <= '0;
          dv_cnt_q <= 7'd95;
          ret_q    <= ST_Q8;
          state_q  <= ST_DIV;
        end
        ST_Q8: begin
          ell_q    <= pos_w;
          dv_neg_q <= num_hi_q[96];
          dv_num_q <= num_hi_mag[95:0];
          dv_rem_q <= '0;
          dv_quo_q <= '0;
          dv_cnt_q <= 7'd95;
          ret_q    <= ST_Q9;
          state_q  <= ST_DIV;
        end
        ST_Q9: begin
          // pos_w now holds the upper crossing u; the q*|dx| product comes
          // back to ST_ACC, which scales it before the accumulate step
          mul_a_q <= {32'b0, qa_q};
          prod_q  <= '0;
          mcnt_q  <= '0;
          priority if (in_l_q) begin
            mul_b_q <= 64'(mag50(dx_us));
            ret_q   <= ST_ACC;
            state_q <= ST_MUL;
          end else if (in_r_q) begin
            mul_b_q <= 64'(mag50(dx_ee));
            ret_q   <= ST_ACC;
            state_q <= ST_MUL;
          end else if ((pos_w < 49'(xs_q)) || (ell_q > 49'(xe_q))) begin
            len_q   <= '0;
            ret_q   <= ST_IDLE;
            state_q <= ST_ACC;
          end else begin
            mul_b_q <= 64'(mag50(dx_ue));
            ret_q   <= ST_ACC;
            state_q <= ST_MUL;
          end
        end
        ST_ACC: begin
          if (ret_q == ST_ACC) begin
            // coming back from the q*|dx| product
            len_q <= prod_q[79:16];
            ret_q <= ST_IDLE;
          end else if (!(last_q && out_valid_q && out_stall_i)) begin
            if (sum_w >= {16'b0, DensMax}) begin
              dens_q <= DensMax;
              sat_q  <= 1'b1;
            end else begin
              dens_q <= sum_w[DensW-1:0];
            end
            if (last_q) begin
              density_o   <= (sum_w >= {16'b0, DensMax}) ? DensMax : sum_w[DensW-1:0];
              saturated_o <= sat_q | (sum_w >= {16'b0, DensMax});
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### bench/segment_disk_overlap_density_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for segment_disk_overlap_density: a queue-fed driver,
// a clocked monitor and an exact bit-level density predictor.
// Depends on sdod_pkg and the block itself.
module segment_disk_overlap_density_tb;
  import sdod_pkg::*;

  typedef struct {
    logic signed [31:0] px, py, xs, ys, xe, ye, m, k;
    logic first, last;
  } pair_t;

  typedef struct {
    logic [DensW-1:0] dens;
    logic sat;
  } dens_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [RadW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] pixel_x_i = '0, pixel_y_i = '0;
  logic signed [31:0] seg_x_start_i = '0, seg_y_start_i = '0;
  logic signed [31:0] seg_x_end_i = '0, seg_y_end_i = '0;
  logic signed [31:0] seg_slope_i = '0, seg_intercept_i = '0;
  logic first_of_pixel_i = 1'b0, last_of_pixel_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [DensW-1:0] density_o;
  logic saturated_o;

  segment_disk_overlap_density dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  pair_t pending_pairs[$];
  dens_res_t expected_dens[$];
  pair_t cur_pair;

  logic [RadW-1:0] radius_q = RadiusReset;
  logic [DensW-1:0] dens_acc = '0;
  logic dens_sat = 1'b0;

  int failures = 0;
  int words_sent = 0;
  int results_seen = 0;
  int sat_results = 0;
  int radius_settings = 1;
  int feed_gap = 0;
  int stall_left = 0;
  logic quiet = 1'b0;

  // ---------------- density predictor ----------------
  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [127:0] square(longint v);
    logic [63:0] a;
    a = mag(v);
    return {64'b0, a} * {64'b0, a};
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] x);
    logic [63:0] res, c;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if ({64'b0, c} * {64'b0, c} <= x) res = c;
    end
    return res;
  endfunction

  // truncating signed division, quotient kept to 47 bits
  function automatic longint root_div(logic [127:0] n, logic [63:0] dv);
    logic neg;
    logic [127:0] nm;
    logic [63:0] q;
    neg = n[127];
    nm = neg ? -n : n;
    q = 64'(nm / {64'b0, dv});
    q &= 64'h7FFF_FFFF_FFFF;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [63:0] scale_len(logic [63:0] qa, longint dx);
    logic [127:0] p;
    p = {64'b0, qa} * {64'b0, mag(dx)};
    return p[79:16];
  endfunction

  function automatic logic [63:0] covered_len(pair_t w, logic [RadW-1:0] rad);
    longint px, py, xs, ys, xe, ye, m, k, d, ell, u;
    logic [63:0] rr, r2, a, s, qa;
    logic [127:0] ar2, dd, md, base, sh;
    logic in_s, in_e;
    px = w.px; py = w.py; xs = w.xs; ys = w.ys;
    xe = w.xe; ye = w.ye; m = w.m; k = w.k;
    rr = 64'(rad);
    r2 = rr * rr;
    in_s = square(px - xs) + square(py - ys) <= {64'b0, r2};
    in_e = square(px - xe) + square(py - ye) <= {64'b0, r2};
    if (in_s && in_e) return isqrt(square(xe - xs) + square(ye - ys));
    a = 64'h1_0000_0000 + 64'(m * m);
    d = k * 65536 + m * px - py * 65536;
    ar2 = {64'b0, a} * {64'b0, r2};
    dd = square(d);
    if (ar2 < dd) return '0;
    s = isqrt(ar2 - dd);
    qa = isqrt({64'b0, a});
    md = {64'b0, mag(m)} * {64'b0, mag(d)};
    if ((m < 0) != (d < 0)) md = -md;
    base = -md;
    sh = {64'b0, s} << 16;
    ell = px + root_div(base - sh, a);
    u = px + root_div(base + sh, a);
    if (in_s) return scale_len(qa, u - xs);
    if (in_e) return scale_len(qa, xe - ell);
    if (u < xs || ell > xe) return '0;
    return scale_len(qa, u - ell);
  endfunction

  function automatic void accumulate_pair(pair_t w);
    logic [63:0] sum;
    dens_res_t r;
    if (w.first) begin
      dens_acc = '0;
      dens_sat = 1'b0;
    end
    sum = {16'b0, dens_acc} + covered_len(w, radius_q);
    if (sum >= {16'b0, DensMax}) begin
      sum = {16'b0, DensMax};
      dens_sat = 1'b1;
    end
    dens_acc = sum[DensW-1:0];
    if (w.last) begin
      r.dens = dens_acc;
      r.sat = dens_sat;
      expected_dens.push_back(r);
    end
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic pair_t mk_pair(longint px, longint py, longint xs, longint ys,
                                    longint xe, longint ye, longint m, longint k,
                                    logic f, logic l);
    pair_t w;
    w.px = 32'(px); w.py = 32'(py); w.xs = 32'(xs); w.ys = 32'(ys);
    w.xe = 32'(xe); w.ye = 32'(ye); w.m = 32'(m); w.k = 32'(k);
    w.first = f; w.last = l;
    return w;
  endfunction

  function automatic longint spread(longint s);
    return longint'($urandom_range(0, 32'(2 * s))) - s;
  endfunction

  // one pixel: a few line-consistent segments near the pixel, some noise
  function automatic void add_random_pixel(longint rad);
    int n;
    logic broken;
    longint sp, px, py, m, k, xs, xe, t;
    pair_t w;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
    broken = $urandom_range(0, 19) == 0;
    sp = rad < 16 ? 16 : (rad > 64'd1 << 28 ? 64'd1 << 28 : rad);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        w = mk_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, 1'b0, 1'b0);
      end else begin
        px = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
        py = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
        m = ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom_range(0, 1 << 19)) - (1 << 18);
        k = py - ((m * px) >>> 16) + spread(2 * sp);
        xs = px + spread(2 * sp);
        xe = xs + longint'($urandom_range(0, 32'(3 * sp)));
        if ($urandom_range(0, 15) == 0) begin
          t = xs; xs = xe; xe = t;
        end
        w = mk_pair(px, py, xs, ((m * xs) >>> 16) + k, xe, ((m * xe) >>> 16) + k,
                    m, k, 1'b0, 1'b0);
      end
      w.first = broken ? 1'($urandom) : (i == 0);
      w.last = (i == n - 1) ? 1'b1 : (broken ? 1'($urandom) : 1'b0);
      pending_pairs.push_back(w);
    end
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk_i) begin
    if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        accumulate_pair(cur_pair);
        words_sent++;
      end
      if (feed_gap > 0) begin
        feed_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        cur_pair = pending_pairs.pop_front();
        pixel_x_i <= cur_pair.px;
        pixel_y_i <= cur_pair.py;
        seg_x_start_i <= cur_pair.xs;
        seg_y_start_i <= cur_pair.ys;
        seg_x_end_i <= cur_pair.xe;
        seg_y_end_i <= cur_pair.ye;
        seg_slope_i <= cur_pair.m;
        seg_intercept_i <= cur_pair.k;
        first_of_pixel_i <= cur_pair.first;
        last_of_pixel_i <= cur_pair.last;
        in_valid_i <= 1'b1;
        feed_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    dens_res_t e;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (saturated_o) sat_results++;
      if (expected_dens.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: unexpected density word %h sat %b", density_o, saturated_o);
      end else begin
        e = expected_dens.pop_front();
        if (density_o !== e.dens || saturated_o !== e.sat) begin
          failures++;
          if (failures <= 10)
            $display("ERROR: density exp %h act %h, saturated exp %b act %b",
                     e.dens, density_o, e.sat, saturated_o);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) quiet <= !quiet;
  end

  // ---------------- sequencing ----------------
  task automatic drain();
    do @(posedge clk_i);
    while (pending_pairs.size() > 0 || in_valid_i || expected_dens.size() > 0);
    // a word without a last mark may still be in flight
    repeat (500) @(posedge clk_i);
  endtask

  task automatic set_radius(logic [RadW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    radius_q = v;
    radius_settings++;
  endtask

  task automatic run_random(int n);
    int start;
    start = pending_pairs.size();
    while (pending_pairs.size() - start < n) add_random_pixel(longint'(radius_q));
  endtask

  initial begin
    logic [RadW-1:0] rads[4];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unit radius: each coverage case once
    pending_pairs.push_back(mk_pair(0, 0, -'h4000, 0, 'h4000, 0, 0, 0, 1, 1));
    pending_pairs.push_back(mk_pair(0, 0, 0, 0, 'h30000, 0, 0, 0, 1, 1));
    pending_pairs.push_back(mk_pair(0, 0, -'h30000, 0, 0, 0, 0, 0, 1, 1));
    pending_pairs.push_back(mk_pair(0, 0, -'h30000, 0, 'h30000, 0, 0, 0, 1, 1));
    pending_pairs.push_back(mk_pair(0, 0, 'h20000, 0, 'h30000, 0, 0, 0, 1, 1));
    // line misses the circle
    pending_pairs.push_back(mk_pair(0, 0, -'h30000, 'h30000, 'h30000, 'h30000,
                                    0, 'h30000, 1, 1));
    pending_pairs.push_back(mk_pair(0, 0, -'h20000, -'h20000, 'h20000, 'h20000,
                                    'h10000, 0, 1, 1));
    pending_pairs.push_back(mk_pair(0, 0, -'h4000, 0, 'h4000, 0, 0, 0, 1, 0));
    pending_pairs.push_back(mk_pair(0, 0, 0, 0, 'h30000, 0, 0, 0, 0, 0));
    pending_pairs.push_back(mk_pair(0, 0, -'h30000, 0, 'h30000, 0, 0, 0, 0, 1));
    // start above end
    pending_pairs.push_back(mk_pair(0, 0, 'h30000, 0, -'h30000, 0, 0, 0, 1, 1));
    pending_pairs.push_back(mk_pair('h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF,
                                    'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF, 1, 1));
    pending_pairs.push_back(mk_pair(-'h80000000, -'h80000000, -'h80000000, -'h80000000,
                                    -'h80000000, -'h80000000, -'h80000000, -'h80000000,
                                    1, 1));
    pending_pairs.push_back(mk_pair(0, 0, 0, 0, 'h8000, 0, 0, 0, 0, 1));
    run_random(200);
    drain();

    // zero radius: a point segment sitting on the pixel is still inside
    set_radius('0);
    pending_pairs.push_back(mk_pair('h10000, 'h10000, 'h10000, 'h10000,
                                    'h10000, 'h10000, 0, 'h10000, 1, 1));
    run_random(200);
    drain();

    // full radius: steep end-inside pairs add about 2^46 each and saturate
    set_radius({RadW{1'b1}});
    for (int i = 0; i < 6; i++)
      pending_pairs.push_back(mk_pair(0, 0, -'h80000000, 'h7FFFFFFF, 'h7FFFFFFF, 0,
                                      -'h80000000, 0, i == 0, i == 5));
    pending_pairs.push_back(mk_pair(0, 0, -'h4000, 0, 'h4000, 0, 0, 0, 1, 1));
    run_random(200);
    drain();

    rads[0] = RadW'(1);
    rads[1] = RadW'($urandom_range(1 << 12, 1 << 18));
    rads[2] = RadW'($urandom_range(1 << 18, 1 << 24));
    rads[3] = RadW'($urandom);
    foreach (rads[i]) begin
      set_radius(rads[i]);
      run_random(150);
      drain();
    end

    $display("Ran %0d segment words over %0d radius settings; %0d pixel densities checked,",
             words_sent, radius_settings, results_seen);
    $display("%0d of them saturated, %0d mismatches.", sat_results, failures);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timeout with %0d words left to send", pending_pairs.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
hdl/sdod_pkg.sv
hdl/segment_disk_overlap_density.sv
bench/segment_disk_overlap_density_tb.sv
